// ===== rtl/apiq_pkg.sv =====
// Package for the aging priority insert queue.
// Holds the opcode and status codes, the slot word and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package apiq_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [2:0] CLASS_MAX = 3'd7;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // one ring slot: class after aging, tag, one yield already taken
  typedef struct packed {
    logic [2:0] cls;
    logic [7:0] tag;
    logic       yld;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CMP,
    S_POP,
    S_DONE
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/apiq_if.sv =====
// Handshake channels of the aging priority insert queue.
// apiq_cmd_if carries push/pop items in, apiq_rsp_if carries results out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface apiq_cmd_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [1:0] req_class;
  logic [7:0] req_tag;

  modport source (output valid, output op, output req_class, output req_tag, input ready);
  modport sink   (input valid, input op, input req_class, input req_tag, output ready);
endinterface

interface apiq_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] out_class;
  logic [7:0] out_tag;
  logic [2:0] occupancy;

  modport source (output valid, output status, output out_class, output out_tag,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_class, input out_tag,
                  input occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/aging_priority_insert_queue_unit.sv =====
// Aging priority insert queue: sorted ring of requesters with class aging.
// Uses apiq_pkg (codes, slot type, states) and apiq_cmd_if / apiq_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

//  channel | dir | payload                                | accepted when
//  cmd     | in  | op, req_class, req_tag                 | cmd.valid && cmd.ready
//  rsp     | out | status, out_class, out_tag, occupancy  | rsp.valid && rsp.ready
//
//  Push: the walk ends at the head or stops at an entry of equal or higher class;
//  k = entries passed (k <= RING_SLOTS-2);
//  each step is one read of the slot memory and a compare, then a write.
//  Pop: the head read has registered data. Full or empty: straight to the result.
//  One item at a time; cmd.ready is high only between items. A finished
//  result waits in the output register while the next item is taken.
//  Synchronous reset clears pointers and count; slots need no clearing.
module aging_priority_insert_queue_unit #(
  parameter int RING_SLOTS = 8
) (
  input  wire          clk,
  input  wire          rst,
  apiq_cmd_if.sink     cmd,
  apiq_rsp_if.source   rsp
);

  localparam int PW = $clog2(RING_SLOTS);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PW'(RING_SLOTS - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    ring_prev = (p == '0) ? PW'(RING_SLOTS - 1) : p - PW'(1);
  endfunction

  apiq_pkg::slot_t mem [RING_SLOTS];
  apiq_pkg::slot_t rd_word;
  apiq_pkg::slot_t wr_data;
  apiq_pkg::slot_t new_slot;
  apiq_pkg::slot_t aged_slot;
  logic            rd_en;
  logic [PW-1:0]   rd_addr;
  logic            wr_en;
  logic [PW-1:0]   wr_addr;

  apiq_pkg::seq_state_t state, state_next;
  logic [PW-1:0]   head, head_next;
  logic [PW-1:0]   tail, tail_next;
  logic [PW-1:0]   pos, pos_next;
  logic [PW-1:0]   count, count_next;
  logic [1:0]      cls_r, cls_next;
  logic [7:0]      tag_r, tag_next;
  apiq_pkg::status_t status_r, status_next;
  logic [2:0]      oclass_r, oclass_next;
  logic [7:0]      otag_r, otag_next;

  logic            push_done;
  logic            out_load;
  logic            cmd_ready;
  logic [PW+2:0]   count_ext;

  logic            rsp_valid;
  logic [1:0]      rsp_status;
  logic [2:0]      rsp_class;
  logic [7:0]      rsp_tag;
  logic [2:0]      rsp_occ;

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign new_slot = '{cls: {1'b0, cls_r}, tag: tag_r, yld: 1'b0};

  // entry moving back one slot: second yield bumps class and clears the flag
  always_comb begin
    aged_slot = rd_word;
    if (rd_word.yld) begin
      aged_slot.yld = 1'b0;
      if (rd_word.cls != apiq_pkg::CLASS_MAX) begin
        aged_slot.cls = rd_word.cls + 3'd1;
      end
    end else begin
      aged_slot.yld = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apiq_pkg::S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    cls_r    <= cls_next;
    tag_r    <= tag_next;
    status_r <= status_next;
    oclass_r <= oclass_next;
    otag_r   <= otag_next;
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    pos_next    = pos;
    count_next  = count;
    cls_next    = cls_r;
    tag_next    = tag_r;
    status_next = status_r;
    oclass_next = oclass_r;
    otag_next   = otag_r;
    rd_en       = 1'b0;
    rd_addr     = head;
    wr_en       = 1'b0;
    wr_addr     = pos;
    wr_data     = new_slot;
    push_done   = 1'b0;
    out_load    = 1'b0;
    cmd_ready   = 1'b0;

    case (state)
      apiq_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd.valid) begin
          cls_next    = cmd.req_class;
          tag_next    = cmd.req_tag;
          oclass_next = '0;
          otag_next   = '0;
          if (cmd.op == apiq_pkg::OP_PUSH) begin
            if (head == ring_next(tail)) begin
              status_next = apiq_pkg::ST_FULL;
              state_next  = apiq_pkg::S_DONE;
            end else begin
              pos_next   = tail;
              state_next = apiq_pkg::S_WALK;
            end
          end else begin
            if (head == tail) begin
              status_next = apiq_pkg::ST_EMPTY;
              state_next  = apiq_pkg::S_DONE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = head;
              state_next = apiq_pkg::S_POP;
            end
          end
        end
      end
      apiq_pkg::S_WALK: begin
        // walk stops at the head without looking before it
        if (pos == head) begin
          push_done = 1'b1;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = ring_prev(pos);
          state_next = apiq_pkg::S_CMP;
        end
      end
      apiq_pkg::S_CMP: begin
        if (rd_word.cls >= {1'b0, cls_r}) begin
          push_done = 1'b1;
        end else begin
          wr_en      = 1'b1;
          wr_data    = aged_slot;
          pos_next   = ring_prev(pos);
          state_next = apiq_pkg::S_WALK;
        end
      end
      apiq_pkg::S_POP: begin
        oclass_next = rd_word.cls;
        otag_next   = rd_word.tag;
        head_next   = ring_next(head);
        count_next  = count - PW'(1);
        status_next = apiq_pkg::ST_POPPED;
        state_next  = apiq_pkg::S_DONE;
      end
      apiq_pkg::S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = apiq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = apiq_pkg::S_IDLE;
      end
    endcase

    if (push_done) begin
      wr_en       = 1'b1;
      wr_data     = new_slot;
      tail_next   = ring_next(tail);
      count_next  = count + PW'(1);
      status_next = apiq_pkg::ST_PUSHED;
      state_next  = apiq_pkg::S_DONE;
    end
  end

  assign count_ext = {3'b000, count};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_status <= status_r;
      rsp_class  <= oclass_r;
      rsp_tag    <= otag_r;
      rsp_occ    <= count_ext[2:0];
    end
  end

  assign cmd.ready     = cmd_ready;
  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.out_class = rsp_class;
  assign rsp.out_tag   = rsp_tag;
  assign rsp.occupancy = rsp_occ;

  // pointer distance, for checking the count
  logic [PW:0] ptr_diff;
  assign ptr_diff = (tail >= head) ? ({1'b0, tail} - {1'b0, head})
                                   : ({1'b0, tail} + (PW + 1)'(RING_SLOTS) - {1'b0, head});

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= PW'(RING_SLOTS - 1))
    else $error("entry count exceeds ring capacity");

  a_count_ptrs: assert property (@(posedge clk) disable iff (rst)
    state == apiq_pkg::S_IDLE |-> ptr_diff == {1'b0, count})
    else $error("entry count out of step with head and tail");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == apiq_pkg::S_WALK || state == apiq_pkg::S_CMP))
    else $error("slot write outside a push walk");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == apiq_pkg::S_DONE)
    else $error("result raised outside the finish step");

endmodule

`default_nettype wire
